/* rtl/trailing_moving_average_macros.svh */
// ============================================================================
// trailing_moving_average_macros.svh
// Assertion macros for the trailing moving average block
// ============================================================================
`ifndef TRAILING_MOVING_AVERAGE_MACROS_SVH
`define TRAILING_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tma_pkg.sv */
// ============================================================================
// tma_pkg
// Shared widths, defaults and types for the trailing moving average block
// ============================================================================
package tma_pkg;

    // fixed field widths
    localparam int DATA_W         = 32;
    localparam int WIN_W          = 7;
    localparam int DEF_MAX_WINDOW = 64;

    // status from the ring summing sequencer to the top level
    typedef struct packed {
        logic             done;
        logic [WIN_W-1:0] used;
    } tma_sum_stat_t;

endpackage

/* rtl/tma_div.sv */
// ============================================================================
// tma_div
// Bit-serial restoring divider: one quotient bit per cycle
// ============================================================================
module tma_div #(
    parameter int SUM_W = 38
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [SUM_W-1:0]           dividend,
    input  logic [tma_pkg::WIN_W-1:0]  divisor,
    output logic                       done,
    output logic [tma_pkg::DATA_W-1:0] quotient
);
    import tma_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] num_reg,  num_next;
    logic [WIN_W-1:0] rem_reg,  rem_next;
    logic [WIN_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIN_W:0]   trial;
    logic [WIN_W:0]   diff;
    logic             qbit;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        trial = {rem_reg, num_reg[SUM_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    // step sequencing
    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[SUM_W-2:0], qbit};
            rem_next = qbit ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg[DATA_W-1:0];

endmodule

/* rtl/tma_ring_sum.sv */
// ============================================================================
// tma_ring_sum
// Sample ring with a sequencer that sums the newest samples one per cycle
// ============================================================================
module tma_ring_sum #(
    parameter int MAX_WINDOW = tma_pkg::DEF_MAX_WINDOW,
    parameter int SUM_W      = tma_pkg::DATA_W + $clog2(MAX_WINDOW)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [tma_pkg::DATA_W-1:0] sample,
    input  logic                       restart,
    input  logic [tma_pkg::WIN_W-1:0]  window_len,
    output tma_pkg::tma_sum_stat_t     stat,
    output logic [SUM_W-1:0]           sum
);
    import tma_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int UW = (CW > WIN_W) ? CW : WIN_W;

    logic [DATA_W-1:0] ring_mem [MAX_WINDOW];

    logic [AW-1:0]     write_slot_reg;
    logic [CW-1:0]     fill_count_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [WIN_W-1:0]  remain_reg;
    logic [WIN_W-1:0]  used_reg;
    logic              issue_reg;
    logic              rd_vld_reg;
    logic              done_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic [SUM_W-1:0]  acc_reg;

    logic [AW-1:0]     slot;
    logic [AW-1:0]     slot_inc;
    logic [CW-1:0]     fill_new;
    logic [UW-1:0]     win_eff;
    logic [UW-1:0]     used_w;

    // slot, fill level and sample count for a new transfer
    always_comb begin
        slot     = restart ? '0 : write_slot_reg;
        slot_inc = (slot == AW'(MAX_WINDOW - 1)) ? '0 : slot + AW'(1);
        if (restart) begin
            fill_new = CW'(1);
        end else if (fill_count_reg == CW'(MAX_WINDOW)) begin
            fill_new = fill_count_reg;
        end else begin
            fill_new = fill_count_reg + CW'(1);
        end
        if (window_len == '0) begin
            win_eff = UW'(1);
        end else if (UW'(window_len) > UW'(MAX_WINDOW)) begin
            win_eff = UW'(MAX_WINDOW);
        end else begin
            win_eff = UW'(window_len);
        end
        used_w = (win_eff > UW'(fill_new)) ? UW'(fill_new) : win_eff;
    end

    // ring write on a new sample
    always_ff @(posedge aclk) begin
        if (start) begin
            ring_mem[slot] <= sample;
        end
    end

    // registered ring read while walking back
    always_ff @(posedge aclk) begin
        if (issue_reg) begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    // series state and read sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg <= '0;
            fill_count_reg <= '0;
            issue_reg      <= 1'b0;
            rd_vld_reg     <= 1'b0;
            done_reg       <= 1'b0;
            remain_reg     <= '0;
            rd_ptr_reg     <= '0;
        end else begin
            rd_vld_reg <= issue_reg;
            done_reg   <= rd_vld_reg && !issue_reg;
            if (start) begin
                write_slot_reg <= slot_inc;
                fill_count_reg <= fill_new;
                rd_ptr_reg     <= slot;
                remain_reg     <= used_w[WIN_W-1:0];
                issue_reg      <= 1'b1;
            end else if (issue_reg) begin
                rd_ptr_reg <= (rd_ptr_reg == '0) ? AW'(MAX_WINDOW - 1)
                                                 : rd_ptr_reg - AW'(1);
                remain_reg <= remain_reg - WIN_W'(1);
                if (remain_reg == WIN_W'(1)) begin
                    issue_reg <= 1'b0;
                end
            end
        end
    end

    // accumulate the samples read back
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg  <= '0;
            used_reg <= used_w[WIN_W-1:0];
        end else if (rd_vld_reg) begin
            acc_reg <= acc_reg + SUM_W'(rd_data_reg);
        end
    end

    assign stat.done = done_reg;
    assign stat.used = used_reg;
    assign sum       = acc_reg;

endmodule

/* rtl/trailing_moving_average.sv */
// Flow: an input transfer starts a ring walk that reads the newest samples back one per cycle
//   into the sum, then the divider works out one quotient bit per cycle, and the result
//   waits in ST_PUT until the output register is free.
// Items: one at a time; the next input transfer is taken once the result sits in the output
//   register.
// Reset: aresetn synchronous, active low; clears the series, window_len to 1, no result.
// ============================================================================
// trailing_moving_average
// Trailing moving average of daily totals over a ring of recent samples
// ============================================================================
module trailing_moving_average #(
    parameter int MAX_WINDOW = tma_pkg::DEF_MAX_WINDOW
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [tma_pkg::WIN_W-1:0]  cfg_wr_data,   // window_len
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [tma_pkg::DATA_W-1:0] s_tdata,       // [31:0] daily_total
    input  logic                       s_tuser,       // [0] restart
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [39:0]                m_tdata        // [31:0] average, [38:32] samples_used
);
    import tma_pkg::*;

    `include "trailing_moving_average_macros.svh"

    localparam int SUM_W = DATA_W + $clog2(MAX_WINDOW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [WIN_W-1:0]  window_len_reg;
    logic              m_tvalid_reg;
    logic [39:0]       m_tdata_reg;

    tma_sum_stat_t     ring_stat;
    logic [SUM_W-1:0]  ring_sum;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;
    logic              in_xfer;
    logic              out_free;
    logic              load_out;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = (state_reg == ST_PUT) && out_free;

    // window register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WIN_W'(1);
        end else if (cfg_wr_en) begin
            window_len_reg <= cfg_wr_data;
        end
    end

    // ring and summing sequencer
    tma_ring_sum #(
        .MAX_WINDOW (MAX_WINDOW),
        .SUM_W      (SUM_W)
    ) u_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (in_xfer),
        .sample     (s_tdata),
        .restart    (s_tuser),
        .window_len (window_len_reg),
        .stat       (ring_stat),
        .sum        (ring_sum)
    );

    // divide sum by sample count
    tma_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ring_stat.done),
        .dividend (ring_sum),
        .divisor  (ring_stat.used),
        .done     (div_done),
        .quotient (div_quot)
    );

    // item sequencing
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xfer)        state_next = ST_SUM;
            ST_SUM:  if (ring_stat.done) state_next = ST_DIV;
            ST_DIV:  if (div_done)       state_next = ST_PUT;
            ST_PUT:  if (out_free)       state_next = ST_IDLE;
            default:                     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {1'b0, ring_stat.used, div_quot};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `TMA_ASSERT_NEXT(a_accept_starts_sum, in_xfer, state_reg == ST_SUM, "transfer did not start summing")
    `TMA_ASSERT_NOW(a_sum_done_in_sum, ring_stat.done, state_reg == ST_SUM, "sum done outside summing")
    `TMA_ASSERT_NOW(a_div_done_in_div, div_done, state_reg == ST_DIV, "divide done outside divide")
    `TMA_ASSERT_NOW(a_result_count, m_tvalid_reg, m_tdata_reg[38:32] != '0, "result with zero samples")

endmodule
